// ----- sv/fme_pkg.sv -----
// Shared constants and types of the fuzzy membership evaluator.
package fme_pkg;

   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 15;
   localparam int CSR_ADDR_WIDTH = 3;

   localparam logic [1:0] SHAPE_TRIANGLE  = 2'd0;
   localparam logic [1:0] SHAPE_GAMMA     = 2'd1;
   localparam logic [1:0] SHAPE_TRAPEZOID = 2'd2;
   localparam logic [1:0] SHAPE_SCURVE    = 2'd3;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SHAPE_MODE = 3'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_BP_FIRST   = 3'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_BP_SECOND  = 3'd2;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_BP_THIRD   = 3'd3;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_BP_FOURTH  = 3'd4;

   typedef enum logic [1:0] {
      POST_NONE,
      POST_SQUARE,
      POST_INV_SQUARE
   } post_type;

   typedef struct packed {
      post_type post;
      logic     force_one;
      logic     degenerate;
   } ctl_type;

endpackage

// ----- sv/fuzzy_membership_evaluator_unit.sv -----
// Top level of the fuzzy membership evaluator: configuration registers and stream ports.
// Path: front register, queue, divider stages, squaring stage, output register.
// Throughput: one item per cycle unless stalled; one quotient bit per divider stage.
// A four-entry queue lets the front end keep accepting while the back end is stalled.
// Reset is synchronous and active high; it empties the pipeline and clears the
// shape mode and all breakpoints to zero.
module fuzzy_membership_evaluator_unit #(
   parameter int DATA_WIDTH = fme_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = fme_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // sample
   input  logic [((DATA_WIDTH+7)/8)*8-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // membership
   output logic [((FRAC_BITS+8)/8)*8-1:0]       rsp_tdata,
   // degenerate
   output logic                                 rsp_tuser,
   input  logic                                 csr_we,
   input  logic [fme_pkg::CSR_ADDR_WIDTH-1:0]   csr_addr,
   input  logic [DATA_WIDTH-1:0]                csr_wdata
);

   localparam int QW = 2 * DATA_WIDTH + $bits(fme_pkg::ctl_type);
   localparam int OW = ((FRAC_BITS + 8) / 8) * 8;

   logic [1:0]            shape_ff;
   logic [DATA_WIDTH-1:0] bp1_ff, bp2_ff, bp3_ff, bp4_ff;

   logic                  f_valid, f_ready, b_valid, b_ready;
   logic [DATA_WIDTH-1:0] f_num, f_den;
   fme_pkg::ctl_type      f_ctl;
   logic [QW-1:0]         q_out;
   logic [FRAC_BITS:0]    membership;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff <= '0;
         bp1_ff   <= '0;
         bp2_ff   <= '0;
         bp3_ff   <= '0;
         bp4_ff   <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            fme_pkg::CSR_SHAPE_MODE: shape_ff <= csr_wdata[1:0];
            fme_pkg::CSR_BP_FIRST:   bp1_ff   <= csr_wdata;
            fme_pkg::CSR_BP_SECOND:  bp2_ff   <= csr_wdata;
            fme_pkg::CSR_BP_THIRD:   bp3_ff   <= csr_wdata;
            fme_pkg::CSR_BP_FOURTH:  bp4_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   fme_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .sample     (req_tdata[DATA_WIDTH-1:0]),
      .shape_mode (shape_ff),
      .bp_first   (bp1_ff),
      .bp_second  (bp2_ff),
      .bp_third   (bp3_ff),
      .bp_fourth  (bp4_ff),
      .out_valid  (f_valid),
      .out_ready  (f_ready),
      .out_num    (f_num),
      .out_den    (f_den),
      .out_ctl    (f_ctl)
   );

   fme_queue #(.WIDTH(QW)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (f_valid),
      .wr_ready (f_ready),
      .wr_data  ({f_ctl, f_num, f_den}),
      .rd_valid (b_valid),
      .rd_ready (b_ready),
      .rd_data  (q_out)
   );

   fme_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (b_valid),
      .in_ready       (b_ready),
      .in_num         (q_out[2*DATA_WIDTH-1:DATA_WIDTH]),
      .in_den         (q_out[DATA_WIDTH-1:0]),
      .in_ctl         (fme_pkg::ctl_type'(q_out[QW-1:2*DATA_WIDTH])),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_membership (membership),
      .out_degenerate (rsp_tuser)
   );

   assign rsp_tdata = OW'(membership);

endmodule

// ----- sv/fme_front.sv -----
// Front end: classifies a sample against the breakpoints and forms the ratio operands.
module fme_front #(
   parameter int DATA_WIDTH = fme_pkg::DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [DATA_WIDTH-1:0] sample,
   input  logic [1:0]                   shape_mode,
   input  logic signed [DATA_WIDTH-1:0] bp_first,
   input  logic signed [DATA_WIDTH-1:0] bp_second,
   input  logic signed [DATA_WIDTH-1:0] bp_third,
   input  logic signed [DATA_WIDTH-1:0] bp_fourth,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [DATA_WIDTH-1:0]        out_num,
   output logic [DATA_WIDTH-1:0]        out_den,
   output fme_pkg::ctl_type             out_ctl
);

   localparam int EW = DATA_WIDTH + 2;

   logic signed [EW-1:0] x, p1, p2, p3, p4, num, den;
   logic                 direct_zero, direct_one, flag;
   fme_pkg::post_type    post;
   logic [DATA_WIDTH-1:0] num_in, den_in;
   fme_pkg::ctl_type     ctl_in;

   logic                  vld_ff;
   logic [DATA_WIDTH-1:0] num_ff, den_ff;
   fme_pkg::ctl_type      ctl_ff;

   assign x  = EW'(sample);
   assign p1 = EW'(bp_first);
   assign p2 = EW'(bp_second);
   assign p3 = EW'(bp_third);
   assign p4 = EW'(bp_fourth);

   always_comb begin
      direct_zero = 1'b0;
      direct_one  = 1'b0;
      flag        = 1'b0;
      post        = fme_pkg::POST_NONE;
      num         = '0;
      den         = EW'(1);
      case (shape_mode)
         fme_pkg::SHAPE_TRIANGLE: begin
            if (x <= p1 || x > p3) begin
               direct_zero = 1'b1;
            end else if (x <= p2) begin
               num = x - p1;
               den = p2 - p1;
            end else begin
               num = p3 - x;
               den = p3 - p2;
            end
         end
         fme_pkg::SHAPE_GAMMA: begin
            if (x <= p1) begin
               direct_zero = 1'b1;
            end else if (x < p2) begin
               num = x - p1;
               den = p2 - p1;
            end else begin
               direct_one = 1'b1;
            end
         end
         fme_pkg::SHAPE_TRAPEZOID: begin
            if (x <= p1 || x > p4) begin
               direct_zero = 1'b1;
            end else if (x <= p2) begin
               num = x - p1;
               den = p2 - p1;
            end else if (x <= p3) begin
               direct_one = 1'b1;
            end else begin
               num = p4 - x;
               den = p4 - p3;
            end
         end
         default: begin
            if (x < p1) begin
               direct_zero = 1'b1;
            end else if ((x <<< 1) <= p1 + p2) begin
               if (p2 - p1 <= 0) begin
                  direct_one = 1'b1;
                  flag       = 1'b1;
               end else begin
                  num  = x - p1;
                  den  = p2 - p1;
                  post = fme_pkg::POST_SQUARE;
               end
            end else if (x <= p2) begin
               num  = p2 - x;
               den  = p2 - p1;
               post = fme_pkg::POST_INV_SQUARE;
            end else begin
               direct_one = 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      num_in           = '0;
      den_in           = DATA_WIDTH'(1);
      ctl_in.post      = post;
      ctl_in.force_one = 1'b0;
      ctl_in.degenerate = flag;
      if (direct_one) begin
         ctl_in.force_one = 1'b1;
      end else if (direct_zero) begin
         ctl_in.force_one = 1'b0;
      end else if (den <= 0) begin
         ctl_in.force_one = 1'b1;
      end else if (num <= 0) begin
         ctl_in.force_one = 1'b0;
      end else if (num >= den) begin
         ctl_in.force_one = 1'b1;
      end else begin
         num_in = num[DATA_WIDTH-1:0];
         den_in = den[DATA_WIDTH-1:0];
      end
   end

   assign in_ready = !vld_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         num_ff <= num_in;
         den_ff <= den_in;
         ctl_ff <= ctl_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_ctl   = ctl_ff;

endmodule

// ----- sv/fme_queue.sv -----
// Short first-in first-out queue between the front and back ends.
module fme_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, rptr_ff;
   logic [PW:0]      count_ff;
   logic             push, pop;

   assign wr_ready = count_ff != (PW+1)'(DEPTH);
   assign rd_valid = count_ff != '0;
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;
   assign rd_data  = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) wptr_ff <= wptr_ff + PW'(1);
         if (pop) rptr_ff <= rptr_ff + PW'(1);
         if (push && !pop) count_ff <= count_ff + (PW+1)'(1);
         else if (pop && !push) count_ff <= count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= wr_data;
   end

endmodule

// ----- sv/fme_back.sv -----
// Back end: pipelined restoring divider, squaring stage and output register.
module fme_back #(
   parameter int DATA_WIDTH = fme_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = fme_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [DATA_WIDTH-1:0] in_num,
   input  logic [DATA_WIDTH-1:0] in_den,
   input  fme_pkg::ctl_type      in_ctl,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [FRAC_BITS:0]    out_membership,
   output logic                  out_degenerate
);

   localparam int F  = FRAC_BITS;
   localparam int W  = DATA_WIDTH;
   localparam int PW = 2 * F + 2;
   localparam logic [F:0] ONE_Q = {1'b1, {F{1'b0}}};

   logic                adv;
   logic                vld_ff [F];
   logic [W-1:0]        rem_ff [F];
   logic [W-1:0]        den_ff [F];
   logic [F-1:0]        quo_ff [F];
   fme_pkg::ctl_type    ctl_ff [F];

   logic [F:0]          q_final;
   logic                mvld_ff;
   logic [F:0]          mq_ff;
   logic [PW-1:0]       prod_ff;
   fme_pkg::ctl_type    mctl_ff;

   logic [PW-1:0]       sq;
   logic [F:0]          mem_in;
   logic                ovld_ff;
   logic [F:0]          omem_ff;
   logic                odeg_ff;

   assign adv      = !ovld_ff || out_ready;
   assign in_ready = adv;

   for (genvar k = 0; k < F; k++) begin : g_div
      logic [W-1:0]     src_rem, src_den, rem_in;
      logic [F-1:0]     src_quo;
      fme_pkg::ctl_type src_ctl;
      logic             src_vld;
      logic [W:0]       r2, diff;
      logic             ge;
      if (k == 0) begin : g_first
         assign src_rem = in_num;
         assign src_den = in_den;
         assign src_quo = '0;
         assign src_ctl = in_ctl;
         assign src_vld = in_valid;
      end else begin : g_next
         assign src_rem = rem_ff[k-1];
         assign src_den = den_ff[k-1];
         assign src_quo = quo_ff[k-1];
         assign src_ctl = ctl_ff[k-1];
         assign src_vld = vld_ff[k-1];
      end
      assign r2     = {src_rem, 1'b0};
      assign diff   = r2 - {1'b0, src_den};
      assign ge     = r2 >= {1'b0, src_den};
      assign rem_in = ge ? diff[W-1:0] : r2[W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= src_den;
            quo_ff[k] <= {src_quo[F-2:0], ge};
            ctl_ff[k] <= src_ctl;
         end
      end
   end

   assign q_final = ctl_ff[F-1].force_one ? ONE_Q : {1'b0, quo_ff[F-1]};

   always_comb begin
      sq = prod_ff >> (F - 1);
      case (mctl_ff.post)
         fme_pkg::POST_SQUARE: mem_in = (sq > PW'(ONE_Q)) ? ONE_Q : sq[F:0];
         fme_pkg::POST_INV_SQUARE: mem_in = (sq >= PW'(ONE_Q)) ? '0 : ONE_Q - sq[F:0];
         default: mem_in = mq_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mvld_ff <= 1'b0;
         ovld_ff <= 1'b0;
      end else if (adv) begin
         mvld_ff <= vld_ff[F-1];
         ovld_ff <= mvld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mq_ff   <= q_final;
         prod_ff <= PW'(q_final) * PW'(q_final);
         mctl_ff <= ctl_ff[F-1];
         omem_ff <= mem_in;
         odeg_ff <= mctl_ff.degenerate;
      end
   end

   assign out_valid      = ovld_ff;
   assign out_membership = omem_ff;
   assign out_degenerate = odeg_ff;

endmodule
